FILE: src/page_extent_allocator_defines.svh
// Assertion macros for the page extent allocator.
`ifndef PAGE_EXTENT_ALLOCATOR_DEFINES_SVH
`define PAGE_EXTENT_ALLOCATOR_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PEA_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define PEA_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: src/pea_pkg.sv
// Shared types and constants of the page extent allocator.
package pea_pkg;
    localparam int MAX_PAGES   = 1024;
    localparam int MAX_EXTENTS = 16;
    localparam int PW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int UW = $clog2(MAX_EXTENTS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOSP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] page_count;
        logic [PW-1:0] start_page;
    } t_in;

    typedef struct packed {
        logic [1:0]    status;
        logic [PW-1:0] grant_start;
        logic [CW-1:0] grant_count;
        logic          last;
        logic [CW-1:0] pages_free;
    } t_out;

    // One table entry as it moves along the chain.
    typedef struct packed {
        logic [PW-1:0] first;
        logic [CW-1:0] len;
    } t_ext;

    // Command broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        OP_HOLD, OP_INIT, OP_LEFT, OP_RIGHT, OP_SET, OP_TRIM
    } t_op;

    typedef struct packed {
        t_op           op;
        logic [UW-1:0] idx;
        t_ext          val;
    } t_cellctl;
endpackage

FILE: src/pea_cell.sv
// One table cell: holds an extent and shifts it to or from its neighbors.
module pea_cell (
    input  logic              i_clk,
    input  pea_pkg::t_cellctl i_ctl,
    input  logic [pea_pkg::UW-1:0] i_id,
    input  pea_pkg::t_ext     i_from_lo,
    input  pea_pkg::t_ext     i_from_hi,
    input  pea_pkg::t_ext     i_init,
    output pea_pkg::t_ext     o_ext
);
    import pea_pkg::*;
    t_ext r_ext;
    t_ext n_ext;

    // Shifts move only cells at or beyond the broadcast index; a right shift
    // writes the new entry at the index itself.
    always_comb begin
        n_ext = r_ext;
        case (i_ctl.op)
            OP_INIT:  n_ext = i_init;
            OP_LEFT:  if (i_id >= i_ctl.idx) n_ext = i_from_hi;
            OP_RIGHT: begin
                if (i_id > i_ctl.idx) n_ext = i_from_lo;
                else if (i_id == i_ctl.idx) n_ext = i_ctl.val;
            end
            OP_SET:   if (i_id == i_ctl.idx) n_ext = i_ctl.val;
            OP_TRIM:  if (i_id == i_ctl.idx) n_ext = i_ctl.val;
            default:  n_ext = r_ext;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
    end
    assign o_ext = r_ext;
endmodule

FILE: src/page_extent_allocator.sv
// Top level of the page extent allocator: controller over a chain of extent cells.
//
//  channel | direction | handshake        | payload
//  in      | input     | i_valid/o_ready  | pea_pkg::t_in
//  out     | output    | o_valid/i_ready  | pea_pkg::t_out
//  cfg     | input     | i_cfg_we         | i_cfg_data (total_pages)
//
// An allocate walks the table one cell per cycle while the output is not
// stalled, emitting one grant item per extent; the dropped entries are then
// shifted out of the chain to the left before the block returns to idle. A free
// scans one cell per cycle, updates the table in S_FDO (with a left shift as a
// second step for a double merge) and posts its result from S_OUT. Reset and a
// total write set the table at once; no item is accepted while a result waits
// in the output register.
module page_extent_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pea_pkg::t_in       i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pea_pkg::t_out      o_data,
    input  logic               i_cfg_we,
    input  logic [pea_pkg::CW-1:0] i_cfg_data
);
    import pea_pkg::*;
`include "page_extent_allocator_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_AWALK, S_AWAIT, S_ADROP, S_FSCAN, S_FDO, S_OUT
    } t_state;

    localparam int NE = MAX_EXTENTS;

    t_state        r_state;
    t_in           r_req;
    logic [CW-1:0] r_total, r_free, r_got;
    logic [UW-1:0] r_used, r_i, r_drop;
    logic          r_ovalid;
    t_out          r_out;
    t_cellctl      ctl;
    t_ext          ext [NE];
    t_ext          lo  [NE];
    t_ext          hi  [NE];
    t_ext          init_val;
    logic [CW-1:0] cfg_v;

    // Chain of cells; each sees its lower and upper neighbor.
    for (genvar g = 0; g < NE; g++) begin : g_cell
        assign lo[g] = (g == 0) ? ext[0] : ext[(g == 0) ? 0 : g-1];
        assign hi[g] = (g == NE-1) ? ext[NE-1] : ext[(g == NE-1) ? g : g+1];
        pea_cell u_cell (
            .i_clk(i_clk), .i_ctl(ctl), .i_id(UW'(g)),
            .i_from_lo(lo[g]), .i_from_hi(hi[g]),
            .i_init((g == 0) ? init_val : '0), .o_ext(ext[g])
        );
    end

    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) cfg_v = CW'(1);
        if (cfg_v > CW'(MAX_PAGES)) cfg_v = CW'(MAX_PAGES);
    end

    // Entry at walk index and its predecessor.
    t_ext          cur, prv;
    logic [UW-1:0] im1;
    logic [CW-1:0] rem, take, end_new;
    logic [CW:0]   chk_end, chk_free;
    logic          mprev, mnext, in_tab;
    assign cur = ext[r_i[$clog2(NE)-1:0]];
    assign im1 = r_i - UW'(1);
    assign prv = ext[im1[$clog2(NE)-1:0]];
    assign in_tab = r_i < r_used;
    assign rem = r_req.page_count - r_got;
    assign take = (cur.len > rem) ? rem : cur.len;
    assign end_new = CW'(r_req.start_page) + r_req.page_count;
    assign chk_end = (CW+1)'(r_req.start_page) + (CW+1)'(r_req.page_count);
    assign chk_free = {1'b0, r_free} + {1'b0, r_req.page_count};
    assign mprev = (r_i != '0) && (CW'(prv.first) + prv.len == CW'(r_req.start_page));
    assign mnext = in_tab && (end_new == CW'(cur.first));

    logic          busy_out;
    assign busy_out = r_ovalid && !i_ready;
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;

    // Second step of a double merge: close the gap at r_i.
    logic r_fshift;
    logic fdo_left;
    assign fdo_left = (r_state == S_FDO) && r_fshift;

    always_comb begin
        init_val.first = '0;
        init_val.len   = cfg_v;
        ctl = '{op: OP_HOLD, idx: r_i, val: '0};
        if (!i_rst_n) begin
            init_val.len = CW'(MAX_PAGES);
            ctl.op = OP_INIT;
        end else if (i_cfg_we) begin
            ctl.op = OP_INIT;
        end else begin
            case (r_state)
                S_AWALK: if (!busy_out && take < cur.len) begin
                    ctl.op = OP_TRIM;
                    ctl.val.first = cur.first + PW'(take);
                    ctl.val.len   = cur.len - take;
                end
                S_ADROP: if (r_drop != '0) begin
                    ctl.op = OP_LEFT;
                    ctl.idx = '0;
                end
                S_FDO: begin
                    if (fdo_left) begin
                        // Double merge: second step shifts the chain left over r_i.
                        ctl.op = OP_LEFT;
                    end else if (mprev && mnext) begin
                        ctl.op = OP_SET; ctl.idx = im1;
                        ctl.val.first = prv.first;
                        ctl.val.len = prv.len + r_req.page_count + cur.len;
                    end else if (mprev) begin
                        ctl.op = OP_SET; ctl.idx = im1;
                        ctl.val.first = prv.first;
                        ctl.val.len = prv.len + r_req.page_count;
                    end else if (mnext) begin
                        ctl.op = OP_SET;
                        ctl.val.first = r_req.start_page;
                        ctl.val.len = cur.len + r_req.page_count;
                    end else if (r_used < UW'(NE)) begin
                        ctl.op = OP_RIGHT;
                        ctl.val.first = r_req.start_page;
                        ctl.val.len = r_req.page_count;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_total <= CW'(MAX_PAGES); r_free <= CW'(MAX_PAGES);
            r_used <= UW'(1); r_fshift <= 1'b0;
        end else if (i_cfg_we) begin
            r_total <= cfg_v; r_free <= cfg_v; r_used <= UW'(1);
        end else begin
            // The walk refills the output register itself.
            if (r_ovalid && i_ready && r_state != S_AWALK) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_req <= i_data; r_i <= '0; r_got <= '0;
                    if (i_data.cmd == CMD_ALLOC) begin
                        if (i_data.page_count == '0 || i_data.page_count > r_free) begin
                            r_out <= '{status: (i_data.page_count == '0) ? ST_OK : ST_NOSP,
                                grant_start: '0, grant_count: '0, last: 1'b1,
                                pages_free: r_free};
                            r_ovalid <= 1'b1;
                        end else begin
                            r_free <= r_free - i_data.page_count;
                            r_state <= S_AWALK;
                        end
                    end else begin
                        r_state <= S_FSCAN;
                    end
                end
                S_AWALK: if (!busy_out) begin
                    r_out <= '{status: ST_OK, grant_start: cur.first, grant_count: take,
                        last: (r_got + take == r_req.page_count) || (r_i + 1'b1 == r_used),
                        pages_free: r_free};
                    r_ovalid <= 1'b1;
                    r_got <= r_got + take;
                    if (take < cur.len || r_i + 1'b1 == r_used
                        || r_got + take == r_req.page_count) begin
                        r_drop <= (take < cur.len) ? r_i : r_i + 1'b1;
                        r_state <= S_ADROP;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_ADROP: begin
                    if (r_drop == '0) r_state <= S_IDLE;
                    else begin
                        r_drop <= r_drop - 1'b1;
                        r_used <= r_used - 1'b1;
                    end
                end
                S_FSCAN: begin
                    if (r_req.page_count == '0 || chk_end > {1'b0, r_total}
                        || chk_free > {1'b0, r_total}) begin
                        r_state <= S_OUT;
                        r_out <= '{status: ST_OK, grant_start: '0, grant_count: '0,
                            last: 1'b1, pages_free: r_free};
                    end else if (in_tab && cur.first < r_req.start_page) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_FDO;
                    end
                end
                S_FDO: begin
                    if (r_fshift) begin
                        r_fshift <= 1'b0;
                        r_state <= S_OUT;
                    end else if (!mprev && !mnext && r_used >= UW'(NE)) begin
                        r_out <= '{status: ST_FULL, grant_start: '0, grant_count: '0,
                            last: 1'b1, pages_free: r_free};
                        r_state <= S_OUT;
                    end else begin
                        r_free <= r_free + r_req.page_count;
                        r_out <= '{status: ST_OK, grant_start: '0, grant_count: '0,
                            last: 1'b1, pages_free: r_free + r_req.page_count};
                        if (mprev && mnext) begin
                            r_used <= r_used - 1'b1; r_fshift <= 1'b1;
                        end else begin
                            if (!mprev && !mnext) r_used <= r_used + 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    `PEA_ASSERT_IMPL(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= UW'(NE),
        "extent count out of range")
    `PEA_ASSERT_IMPL(a_free_bound, i_clk, i_rst_n, 1'b1, r_free <= r_total,
        "free count above total")
    `PEA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ready && !i_cfg_we,
        r_ovalid && $stable(r_out), "result changed while stalled")
endmodule
